@@ src/bpc_pkg.sv @@
package bpc_pkg;

    // Field widths of the sensor words and calibration words
    localparam int RAW_W      = 24;
    localparam int CAL_W      = 16;
    localparam int TEMP_OUT_W = 19;
    localparam int PRES_OUT_W = 32;

    // Stream payload widths, padded to whole bytes
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;

    // Configuration port
    localparam int NUM_REGS   = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = CAL_W;

    localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_SENSITIVITY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_OFFSET        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY_TEMP_COEFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP_COEFF      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_TEMPERATURE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMPERATURE_COEFF      = 3'd5;

    // Factory calibration set (C1..C6)
    typedef struct packed {
        logic [CAL_W-1:0] pressure_sensitivity;
        logic [CAL_W-1:0] pressure_offset;
        logic [CAL_W-1:0] sensitivity_temp_coeff;
        logic [CAL_W-1:0] offset_temp_coeff;
        logic [CAL_W-1:0] reference_temperature;
        logic [CAL_W-1:0] temperature_coeff;
    } t_cal;

endpackage

@@ src/baro_pressure_compensation.sv @@
// Barometric pressure / temperature compensation pipeline.
//
// Slave stream: one transaction carries a raw pressure word (D1), a raw
// temperature word (D2) and a flag that enables low-temperature second-order
// correction. Master stream: one transaction per input with the compensated
// pressure in pascals (saturated to signed 32 bits) and the temperature in
// hundredths of a degree Celsius.
// Six 16-bit calibration words (C1..C6) are written on the plain write port
// (index 0..5; other indexes are dropped). Write them only while the pipe is
// empty; they are read directly by the datapath.
// Pipeline: 11 register stages (S1..S11) lie between the input and the master
// side. Throughput: one transaction per cycle while the master side accepts,
// set by the fully pipelined datapath (every multiplier is followed by a
// register, the 64-bit pressure product is split into two 24x20 partial
// products).
// Stall: each stage holds when full and the stage after it cannot move, so
// bubbles collapse and s_axis_tready stays high while any stage is free.
// Reset clears every valid bit and the calibration words to zero.
module baro_pressure_compensation
    import bpc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // d1_pressure[23:0], d2_temperature[47:24], second_order[48], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // pressure_pa[31:0], temperature_centi[50:32], zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int NUM_STAGES = 11;

    localparam logic signed [19:0] TEMP_REF = 20'sd2000;   // 20.00 C
    localparam logic signed [19:0] TEMP_LOW = -20'sd1500;  // -15.00 C
    localparam logic signed [43:0] P_MAX    = 44'sd2147483647;
    localparam logic signed [43:0] P_MIN    = -44'sd2147483648;

    t_cal cal;

    bpc_cal_regs u_cal_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_cal   (cal)
    );

    // ------------------------------------------------------------------
    // Valid bits and per-stage advance
    // ------------------------------------------------------------------
    logic [NUM_STAGES:1] r_vld;
    logic [NUM_STAGES:1] n_adv;

    // A stage may load when it is empty or its contents move on.
    always_comb begin
        n_adv[NUM_STAGES] = !r_vld[NUM_STAGES] || m_axis_tready;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            n_adv[k] = !r_vld[k] || n_adv[k+1];
        end
    end

    assign s_axis_tready = n_adv[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_adv[1]) begin
                r_vld[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= NUM_STAGES; k++) begin
                if (n_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    // S1: dT
    logic [RAW_W-1:0]  r_s1_d1;
    logic signed [24:0] r_s1_dt;
    logic              r_s1_so;
    // S2: products with dT
    logic [RAW_W-1:0]  r_s2_d1;
    logic              r_s2_so;
    logic signed [41:0] r_s2_p6;
    logic signed [41:0] r_s2_p4;
    logic signed [41:0] r_s2_p3;
    logic signed [49:0] r_s2_dsq;
    // S3: first-order TEMP, OFF, SENS and T2
    logic [RAW_W-1:0]  r_s3_d1;
    logic              r_s3_so;
    logic signed [19:0] r_s3_temp;
    logic signed [39:0] r_s3_off1;
    logic signed [39:0] r_s3_sens1;
    logic [17:0]       r_s3_t2;
    // S4: squares of the low-temperature deltas
    logic [RAW_W-1:0]  r_s4_d1;
    logic              r_s4_use2;
    logic              r_s4_low;
    logic [35:0]       r_s4_sq;
    logic [35:0]       r_s4_vsq;
    logic signed [19:0] r_s4_temp;
    logic signed [39:0] r_s4_off1;
    logic signed [39:0] r_s4_sens1;
    // S5: OFF2 / SENS2
    logic [RAW_W-1:0]  r_s5_d1;
    logic [39:0]       r_s5_off2;
    logic [39:0]       r_s5_sens2;
    logic signed [19:0] r_s5_temp;
    logic signed [39:0] r_s5_off1;
    logic signed [39:0] r_s5_sens1;
    // S6: final OFF / SENS
    logic [RAW_W-1:0]  r_s6_d1;
    logic signed [39:0] r_s6_off;
    logic signed [39:0] r_s6_sens;
    logic signed [19:0] r_s6_temp;
    // S7: partial products of D1 * SENS
    logic [43:0]       r_s7_plo;
    logic signed [44:0] r_s7_phi;
    logic signed [39:0] r_s7_off;
    logic signed [19:0] r_s7_temp;
    // S8: full product
    logic signed [63:0] r_s8_prod;
    logic signed [39:0] r_s8_off;
    logic signed [19:0] r_s8_temp;
    // S9: product / 2^21
    logic signed [42:0] r_s9_q;
    logic signed [39:0] r_s9_off;
    logic signed [19:0] r_s9_temp;
    // S10: minus OFF
    logic signed [43:0] r_s10_x;
    logic signed [19:0] r_s10_temp;
    // S11: output register
    logic [PRES_OUT_W-1:0] r_out_p;
    logic [TEMP_OUT_W-1:0] r_out_t;

    // ------------------------------------------------------------------
    // Combinational stage logic
    // ------------------------------------------------------------------
    logic signed [24:0] n_s1_dt;
    logic signed [41:0] n_s3_b6;
    logic signed [41:0] n_s3_b4;
    logic signed [41:0] n_s3_b3;
    logic signed [19:0] n_s3_temp;
    logic signed [39:0] n_s3_off1;
    logic signed [39:0] n_s3_sens1;
    logic signed [19:0] n_s4_lo;
    logic signed [19:0] n_s4_vlo;
    logic signed [39:0] n_s4_sq;
    logic signed [39:0] n_s4_vsq;
    logic               n_s4_use2;
    logic               n_s4_low;
    logic signed [19:0] n_s4_temp;
    logic [39:0]        n_s5_sq5;
    logic [39:0]        n_s5_vsq7;
    logic [39:0]        n_s5_vsq11;
    logic [39:0]        n_s5_off2;
    logic [39:0]        n_s5_sens2;
    logic signed [63:0] n_s8_hi;
    logic signed [63:0] n_s9_b;
    logic signed [43:0] n_out_b;
    logic signed [43:0] n_out_p;
    logic [PRES_OUT_W-1:0] n_out_sat;

    // dT = D2 - C5 * 256
    assign n_s1_dt = $signed({1'b0, s_axis_tdata[47:24]})
                   - $signed({1'b0, cal.reference_temperature, 8'b0});

    // Truncate toward zero: bias negatives by 2^n - 1 before the shift.
    always_comb begin
        n_s3_b6    = r_s2_p6 + (r_s2_p6[41] ? 42'sd8388607 : 42'sd0);
        n_s3_b4    = r_s2_p4 + (r_s2_p4[41] ? 42'sd127 : 42'sd0);
        n_s3_b3    = r_s2_p3 + (r_s2_p3[41] ? 42'sd255 : 42'sd0);
        n_s3_temp  = TEMP_REF + 20'(n_s3_b6 >>> 23);
        n_s3_off1  = $signed({8'b0, cal.pressure_offset, 16'b0}) + 40'(n_s3_b4 >>> 7);
        n_s3_sens1 = $signed({9'b0, cal.pressure_sensitivity, 15'b0}) + 40'(n_s3_b3 >>> 8);
    end

    // Second-order terms use TEMP before T2 comes off.
    always_comb begin
        n_s4_lo   = r_s3_temp - TEMP_REF;
        n_s4_vlo  = r_s3_temp - TEMP_LOW;
        n_s4_sq   = 40'(n_s4_lo * n_s4_lo);
        n_s4_vsq  = 40'(n_s4_vlo * n_s4_vlo);
        n_s4_use2 = r_s3_so && (r_s3_temp < TEMP_REF);
        n_s4_low  = r_s3_temp < TEMP_LOW;
        n_s4_temp = n_s4_use2 ? r_s3_temp - $signed({2'b0, r_s3_t2}) : r_s3_temp;
    end

    // OFF2 = 5*sq/2 (+ 7*vsq), SENS2 = 5*sq/4 (+ 11*vsq/2), all non-negative
    always_comb begin
        n_s5_sq5   = {2'b0, r_s4_sq, 2'b0} + {4'b0, r_s4_sq};
        n_s5_vsq7  = {1'b0, r_s4_vsq, 3'b0} - {4'b0, r_s4_vsq};
        n_s5_vsq11 = {1'b0, r_s4_vsq, 3'b0} + {3'b0, r_s4_vsq, 1'b0} + {4'b0, r_s4_vsq};
        n_s5_off2  = '0;
        n_s5_sens2 = '0;
        if (r_s4_use2) begin
            n_s5_off2  = (n_s5_sq5 >> 1) + (r_s4_low ? n_s5_vsq7 : 40'd0);
            n_s5_sens2 = (n_s5_sq5 >> 2) + (r_s4_low ? (n_s5_vsq11 >> 1) : 40'd0);
        end
    end

    // Recombine D1 * SENS = (D1 * SENS_hi) << 20 + D1 * SENS_lo
    assign n_s8_hi = 64'(r_s7_phi);
    assign n_s9_b  = r_s8_prod + (r_s8_prod[63] ? 64'sd2097151 : 64'sd0);

    always_comb begin
        n_out_b = r_s10_x + (r_s10_x[43] ? 44'sd32767 : 44'sd0);
        n_out_p = n_out_b >>> 15;
        if (n_out_p > P_MAX) begin
            n_out_sat = PRES_OUT_W'(P_MAX);
        end else if (n_out_p < P_MIN) begin
            n_out_sat = PRES_OUT_W'(P_MIN);
        end else begin
            n_out_sat = n_out_p[PRES_OUT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage registers: load when the stage advances, hold otherwise
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (n_adv[1]) begin
            r_s1_d1 <= s_axis_tdata[23:0];
            r_s1_dt <= n_s1_dt;
            r_s1_so <= s_axis_tdata[48];
        end
        if (n_adv[2]) begin
            r_s2_d1  <= r_s1_d1;
            r_s2_so  <= r_s1_so;
            r_s2_p6  <= 42'(r_s1_dt * $signed({1'b0, cal.temperature_coeff}));
            r_s2_p4  <= 42'(r_s1_dt * $signed({1'b0, cal.offset_temp_coeff}));
            r_s2_p3  <= 42'(r_s1_dt * $signed({1'b0, cal.sensitivity_temp_coeff}));
            r_s2_dsq <= 50'(r_s1_dt * r_s1_dt);
        end
        if (n_adv[3]) begin
            r_s3_d1    <= r_s2_d1;
            r_s3_so    <= r_s2_so;
            r_s3_temp  <= n_s3_temp;
            r_s3_off1  <= n_s3_off1;
            r_s3_sens1 <= n_s3_sens1;
            r_s3_t2    <= r_s2_dsq[48:31];
        end
        if (n_adv[4]) begin
            r_s4_d1    <= r_s3_d1;
            r_s4_use2  <= n_s4_use2;
            r_s4_low   <= n_s4_low;
            r_s4_sq    <= n_s4_sq[35:0];
            r_s4_vsq   <= n_s4_vsq[35:0];
            r_s4_temp  <= n_s4_temp;
            r_s4_off1  <= r_s3_off1;
            r_s4_sens1 <= r_s3_sens1;
        end
        if (n_adv[5]) begin
            r_s5_d1    <= r_s4_d1;
            r_s5_off2  <= n_s5_off2;
            r_s5_sens2 <= n_s5_sens2;
            r_s5_temp  <= r_s4_temp;
            r_s5_off1  <= r_s4_off1;
            r_s5_sens1 <= r_s4_sens1;
        end
        if (n_adv[6]) begin
            r_s6_d1   <= r_s5_d1;
            r_s6_off  <= r_s5_off1 - $signed(r_s5_off2);
            r_s6_sens <= r_s5_sens1 - $signed(r_s5_sens2);
            r_s6_temp <= r_s5_temp;
        end
        if (n_adv[7]) begin
            r_s7_plo  <= 44'(r_s6_d1 * r_s6_sens[19:0]);
            r_s7_phi  <= 45'($signed({1'b0, r_s6_d1}) * $signed(r_s6_sens[39:20]));
            r_s7_off  <= r_s6_off;
            r_s7_temp <= r_s6_temp;
        end
        if (n_adv[8]) begin
            r_s8_prod <= (n_s8_hi <<< 20) + $signed({20'b0, r_s7_plo});
            r_s8_off  <= r_s7_off;
            r_s8_temp <= r_s7_temp;
        end
        if (n_adv[9]) begin
            r_s9_q    <= 43'(n_s9_b >>> 21);
            r_s9_off  <= r_s8_off;
            r_s9_temp <= r_s8_temp;
        end
        if (n_adv[10]) begin
            r_s10_x    <= 44'(r_s9_q) - 44'(r_s9_off);
            r_s10_temp <= r_s9_temp;
        end
        if (n_adv[11]) begin
            r_out_p <= n_out_sat;
            r_out_t <= r_s10_temp[TEMP_OUT_W-1:0];
        end
    end

    assign m_axis_tvalid = r_vld[NUM_STAGES];
    assign m_axis_tdata  = {(OUT_TDATA_W - PRES_OUT_W - TEMP_OUT_W)'(0), r_out_t, r_out_p};

endmodule

@@ src/bpc_cal_regs.sv @@
module bpc_cal_regs
    import bpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_idx,
    input  logic [CFG_DATA_W-1:0] i_wdata,
    output t_cal                  o_cal
);

    t_cal r_cal;
    t_cal n_cal;

    always_comb begin
        n_cal = r_cal;
        if (i_we) begin
            case (i_idx)
                REG_PRESSURE_SENSITIVITY:   n_cal.pressure_sensitivity   = i_wdata;
                REG_PRESSURE_OFFSET:        n_cal.pressure_offset        = i_wdata;
                REG_SENSITIVITY_TEMP_COEFF: n_cal.sensitivity_temp_coeff = i_wdata;
                REG_OFFSET_TEMP_COEFF:      n_cal.offset_temp_coeff      = i_wdata;
                REG_REFERENCE_TEMPERATURE:  n_cal.reference_temperature  = i_wdata;
                REG_TEMPERATURE_COEFF:      n_cal.temperature_coeff      = i_wdata;
                default: ; // drop writes past the last register
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else begin
            r_cal <= n_cal;
        end
    end

    assign o_cal = r_cal;

endmodule

@@ src/bpc_checker.sv @@
module bpc_checker
    import bpc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int PAD_LSB = PRES_OUT_W + TEMP_OUT_W;

    // Reset empties the pipe.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered right after reset");

    // An empty output stage always leaves room at the input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    // A stalled result holds.
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while stalled");

    // Padding bits above the temperature field stay zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:PAD_LSB] == '0)
        else $error("nonzero padding in result");

endmodule

bind baro_pressure_compensation bpc_checker u_bpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
